@@ design/i2c_master_reg16_access_defines.svh @@
// Assertion macros shared by the I2C register access block.
`ifndef I2C_MASTER_REG16_ACCESS_DEFINES_SVH
`define I2C_MASTER_REG16_ACCESS_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define I2CM_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");

// Next-cycle implication.
`define I2CM_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");

// Condition that must never hold.
`define I2CM_ASSERT_NEVER(label, clk, rst, a) \
   label: assert property (@(posedge clk) disable iff (rst) !(a)) \
      else $error("forbidden condition seen");

`else

`define I2CM_ASSERT_IMPLY(label, clk, rst, a, b)
`define I2CM_ASSERT_NEXT(label, clk, rst, a, b)
`define I2CM_ASSERT_NEVER(label, clk, rst, a)

`endif

`endif

@@ design/i2cm_pkg.sv @@
// Types and constants of the I2C register access block.
`default_nettype none

package i2cm_pkg;

   localparam int MAX_BYTES = 16;
   localparam int BUF_AW    = $clog2(MAX_BYTES);

   localparam logic [15:0] PHASE_DIV_RESET = 16'd5000;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_BEGIN = 2'd1;
   localparam logic [1:0] OP_PUSH  = 2'd2;

   typedef enum logic [4:0] {
      PH_IDLE, ST_SDA1, ST_SCLH, ST_SDA0, ST_SCLL,
      WB_SDA, WB_SCLH, WB_SCLL, WA_SDA1, WA_SCLH, WA_READ, WA_SCLL,
      RB_SDA1, RB_SCLH, RB_READ, RB_SCLL, RA_SDA, RA_SCLH, RA_SCLL, RA_SDA1,
      SP_SDA0, SP_SCLH, SP_SDA1
   } phase_type;

   typedef enum logic [2:0] {
      SG_ADDR_W, SG_REG_HI, SG_REG_LO, SG_DATA_W, SG_ADDR_R
   } stage_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [6:0]  dev_addr;
      logic [15:0] reg_addr;
      logic [4:0]  byte_count;
      logic        is_read;
      logic [7:0]  wr_byte;
      logic        sda_in;
   } req_item_type;

   typedef struct packed {
      logic        scl_out;
      logic        sda_out;
      logic [7:0]  read_byte;
      logic        read_valid;
      logic        read_last;
      logic        done_res;
      logic        nack_error;
      logic        busy_res;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ design/i2cm_wbuf.sv @@
// Write data buffer: one write port, one registered read port.
`default_nettype none

module i2cm_wbuf (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [i2cm_pkg::BUF_AW-1:0] wr_addr,
   input  wire logic [7:0]                wr_data,
   input  wire logic [i2cm_pkg::BUF_AW-1:0] rd_addr,
   output logic      [7:0]                rd_data
);
   import i2cm_pkg::*;

   logic [7:0] mem [MAX_BYTES];
   logic [7:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/i2cm_seq.sv @@
// Line sequencer, phase divider and command latch around the write buffer.
`default_nettype none
`include "i2c_master_reg16_access_defines.svh"

module i2cm_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [15:0]           csr_wr_data,
   input  wire logic                  item_accept,
   input  wire i2cm_pkg::req_item_type item,
   output i2cm_pkg::rsp_item_type     res
);
   import i2cm_pkg::*;

   phase_type   ph_ff, ph_in;
   stage_type   stage_ff, stage_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;
   logic [4:0]  byte_cnt_ff, byte_cnt_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] div_cnt_ff, div_cnt_in;
   logic [6:0]  cmd_dev_ff, cmd_dev_in;
   logic [15:0] cmd_reg_ff, cmd_reg_in;
   logic [4:0]  cmd_count_ff, cmd_count_in;
   logic        cmd_read_ff, cmd_read_in;
   logic        ack_ff, ack_in;
   logic        err_ff, err_in;
   logic [4:0]  fill_ff, fill_in;
   logic        scl_lvl_ff, scl_lvl_in;
   logic        sda_lvl_ff, sda_lvl_in;
   logic [15:0] pd_ff;

   logic [15:0]        div_eff;
   logic [16:0]        div_sum;
   logic [4:0]         bc_inc;
   logic               last_rd;
   logic               entered;
   logic               buf_consume;
   logic               buf_wr_en;
   logic [BUF_AW-1:0]  buf_wr_addr;
   logic [BUF_AW-1:0]  buf_rd_addr;
   logic [7:0]         buf_rd_data;

   i2cm_wbuf u_wbuf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (item.wr_byte),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   // Prefetch the entry the next data byte will need
   assign bc_inc      = byte_cnt_ff + 5'd1;
   assign buf_rd_addr = (stage_ff == SG_DATA_W) ? bc_inc[BUF_AW-1:0] : '0;
   assign buf_wr_addr = fill_ff[BUF_AW-1:0];

   assign div_eff = (pd_ff == 16'd0) ? 16'd1 : pd_ff;
   assign div_sum = {1'b0, div_cnt_ff} + 17'd1;
   assign last_rd = ({1'b0, byte_cnt_ff} + 6'd1) >= {1'b0, cmd_count_ff};

   // Next state and result for the current item
   always_comb begin
      ph_in        = ph_ff;
      stage_in     = stage_ff;
      bit_cnt_in   = bit_cnt_ff;
      byte_cnt_in  = byte_cnt_ff;
      shift_in     = shift_ff;
      div_cnt_in   = div_cnt_ff;
      cmd_dev_in   = cmd_dev_ff;
      cmd_reg_in   = cmd_reg_ff;
      cmd_count_in = cmd_count_ff;
      cmd_read_in  = cmd_read_ff;
      ack_in       = ack_ff;
      err_in       = err_ff;
      fill_in      = fill_ff;
      scl_lvl_in   = scl_lvl_ff;
      sda_lvl_in   = sda_lvl_ff;
      entered      = 1'b0;
      buf_consume  = 1'b0;
      buf_wr_en    = 1'b0;
      res          = '0;

      case (item.op)
         OP_BEGIN: begin
            if (ph_ff == PH_IDLE) begin
               cmd_dev_in   = item.dev_addr;
               cmd_reg_in   = item.reg_addr;
               cmd_count_in = (item.byte_count > 5'(MAX_BYTES)) ?
                              5'(MAX_BYTES) : item.byte_count;
               cmd_read_in  = item.is_read;
               if (!item.is_read) begin
                  fill_in = '0;
               end
               stage_in    = SG_ADDR_W;
               byte_cnt_in = '0;
               bit_cnt_in  = '0;
               shift_in    = '0;
               ack_in      = 1'b0;
               err_in      = 1'b0;
               div_cnt_in  = '0;
               ph_in       = ST_SDA1;
               entered     = 1'b1;
            end
         end
         OP_PUSH: begin
            if (ph_ff == PH_IDLE && fill_ff < 5'(MAX_BYTES)) begin
               buf_wr_en = item_accept;
               fill_in   = fill_ff + 5'd1;
            end
         end
         OP_TICK: begin
            if (ph_ff != PH_IDLE) begin
               if (div_sum >= {1'b0, div_eff}) begin
                  div_cnt_in = '0;
                  entered    = 1'b1;
                  // End the current line window
                  case (ph_ff)
                     ST_SDA1: ph_in = ST_SCLH;
                     ST_SCLH: ph_in = ST_SDA0;
                     ST_SDA0: ph_in = ST_SCLL;
                     ST_SCLL: begin
                        shift_in   = {cmd_dev_ff, stage_ff == SG_ADDR_R};
                        bit_cnt_in = '0;
                        ph_in      = WB_SDA;
                     end
                     WB_SDA:  ph_in = WB_SCLH;
                     WB_SCLH: ph_in = WB_SCLL;
                     WB_SCLL: begin
                        shift_in   = {shift_ff[6:0], 1'b0};
                        bit_cnt_in = bit_cnt_ff + 4'd1;
                        ph_in      = (bit_cnt_in >= 4'd8) ? WA_SDA1 : WB_SDA;
                     end
                     WA_SDA1: ph_in = WA_SCLH;
                     WA_SCLH: ph_in = WA_READ;
                     WA_READ: begin
                        ack_in = (item.sda_in == 1'b0);
                        ph_in  = WA_SCLL;
                     end
                     WA_SCLL: begin
                        if (!ack_ff) begin
                           err_in = 1'b1;
                           ph_in  = SP_SDA0;
                        end else begin
                           case (stage_ff)
                              SG_ADDR_W: begin
                                 stage_in   = SG_REG_HI;
                                 shift_in   = cmd_reg_ff[15:8];
                                 bit_cnt_in = '0;
                                 ph_in      = WB_SDA;
                              end
                              SG_REG_HI: begin
                                 stage_in   = SG_REG_LO;
                                 shift_in   = cmd_reg_ff[7:0];
                                 bit_cnt_in = '0;
                                 ph_in      = WB_SDA;
                              end
                              SG_REG_LO: begin
                                 if (cmd_read_ff) begin
                                    stage_in = SG_ADDR_R;
                                    ph_in    = ST_SDA1;
                                 end else begin
                                    stage_in    = SG_DATA_W;
                                    byte_cnt_in = '0;
                                    if (cmd_count_ff != 5'd0) begin
                                       buf_consume = 1'b1;
                                       shift_in    = buf_rd_data;
                                       bit_cnt_in  = '0;
                                       ph_in       = WB_SDA;
                                    end else begin
                                       ph_in = SP_SDA0;
                                    end
                                 end
                              end
                              SG_DATA_W: begin
                                 byte_cnt_in = bc_inc;
                                 if (bc_inc < cmd_count_ff) begin
                                    buf_consume = 1'b1;
                                    shift_in    = buf_rd_data;
                                    bit_cnt_in  = '0;
                                    ph_in       = WB_SDA;
                                 end else begin
                                    ph_in = SP_SDA0;
                                 end
                              end
                              default: begin
                                 byte_cnt_in = '0;
                                 if (cmd_count_ff != 5'd0) begin
                                    shift_in   = '0;
                                    bit_cnt_in = '0;
                                    ph_in      = RB_SDA1;
                                 end else begin
                                    ph_in = SP_SDA0;
                                 end
                              end
                           endcase
                        end
                     end
                     RB_SDA1: ph_in = RB_SCLH;
                     RB_SCLH: ph_in = RB_READ;
                     RB_READ: begin
                        shift_in   = {shift_ff[6:0], item.sda_in};
                        bit_cnt_in = bit_cnt_ff + 4'd1;
                        if (bit_cnt_in >= 4'd8) begin
                           res.read_byte  = shift_in;
                           res.read_valid = 1'b1;
                           res.read_last  = last_rd;
                        end
                        ph_in = RB_SCLL;
                     end
                     RB_SCLL: ph_in = (bit_cnt_ff >= 4'd8) ? RA_SDA : RB_SCLH;
                     RA_SDA:  ph_in = RA_SCLH;
                     RA_SCLH: ph_in = RA_SCLL;
                     RA_SCLL: ph_in = RA_SDA1;
                     RA_SDA1: begin
                        byte_cnt_in = bc_inc;
                        if (bc_inc < cmd_count_ff) begin
                           shift_in   = '0;
                           bit_cnt_in = '0;
                           ph_in      = RB_SDA1;
                        end else begin
                           ph_in = SP_SDA0;
                        end
                     end
                     SP_SDA0: ph_in = SP_SCLH;
                     SP_SCLH: ph_in = SP_SDA1;
                     default: begin
                        // STOP window over: report and drop to idle
                        entered        = 1'b0;
                        res.done_res   = 1'b1;
                        res.nack_error = err_ff;
                        ph_in          = PH_IDLE;
                     end
                  endcase
               end else begin
                  div_cnt_in = div_sum[15:0];
               end
            end
         end
         default: ;
      endcase

      // Apply the line action of a newly entered phase
      if (entered) begin
         if (ph_in inside {ST_SDA1, WA_SDA1, RB_SDA1, RA_SDA1, SP_SDA1}) begin
            sda_lvl_in = 1'b1;
         end else if (ph_in inside {ST_SDA0, SP_SDA0}) begin
            sda_lvl_in = 1'b0;
         end else if (ph_in inside {ST_SCLH, WB_SCLH, WA_SCLH, RB_SCLH, RA_SCLH,
                                    SP_SCLH}) begin
            scl_lvl_in = 1'b1;
         end else if (ph_in inside {ST_SCLL, WB_SCLL, WA_SCLL, RB_SCLL, RA_SCLL}) begin
            scl_lvl_in = 1'b0;
         end else if (ph_in == WB_SDA) begin
            sda_lvl_in = shift_in[7];
         end else if (ph_in == RA_SDA) begin
            sda_lvl_in = last_rd;
         end
      end

      res.scl_out  = scl_lvl_in;
      res.sda_out  = sda_lvl_in;
      res.busy_res = (ph_in != PH_IDLE);
   end

   // Hold the divider setting
   always_ff @(posedge clock) begin
      if (reset) begin
         pd_ff <= PHASE_DIV_RESET;
      end else if (csr_wr_en) begin
         pd_ff <= csr_wr_data;
      end
   end

   // Advance the sequencer on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff        <= PH_IDLE;
         stage_ff     <= SG_ADDR_W;
         bit_cnt_ff   <= '0;
         byte_cnt_ff  <= '0;
         shift_ff     <= '0;
         div_cnt_ff   <= '0;
         cmd_dev_ff   <= '0;
         cmd_reg_ff   <= '0;
         cmd_count_ff <= '0;
         cmd_read_ff  <= 1'b0;
         ack_ff       <= 1'b0;
         err_ff       <= 1'b0;
         fill_ff      <= '0;
         scl_lvl_ff   <= 1'b1;
         sda_lvl_ff   <= 1'b1;
      end else if (item_accept) begin
         ph_ff        <= ph_in;
         stage_ff     <= stage_in;
         bit_cnt_ff   <= bit_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         shift_ff     <= shift_in;
         div_cnt_ff   <= div_cnt_in;
         cmd_dev_ff   <= cmd_dev_in;
         cmd_reg_ff   <= cmd_reg_in;
         cmd_count_ff <= cmd_count_in;
         cmd_read_ff  <= cmd_read_in;
         ack_ff       <= ack_in;
         err_ff       <= err_in;
         fill_ff      <= fill_in;
         scl_lvl_ff   <= scl_lvl_in;
         sda_lvl_ff   <= sda_lvl_in;
      end
   end

   // Prefetched buffer data must come from a settled address with no write in flight
   `I2CM_ASSERT_IMPLY(a_buf_prefetch_settled, clock, reset, item_accept && buf_consume, $past(buf_rd_addr) == buf_rd_addr && !$past(buf_wr_en))
   // Leaving a transaction always reports done
   `I2CM_ASSERT_IMPLY(a_done_on_idle, clock, reset, item_accept && ph_ff != PH_IDLE && ph_in == PH_IDLE, res.done_res)
   // Received bytes only appear in a read transaction
   `I2CM_ASSERT_IMPLY(a_read_only_in_read, clock, reset, item_accept && res.read_valid, cmd_read_ff && stage_ff == SG_ADDR_R)

endmodule

`default_nettype wire

@@ design/i2cm_rsp_q.sv @@
// Two-entry result queue between the sequencer and the result channel.
`default_nettype none
`include "i2c_master_reg16_access_defines.svh"

module i2cm_rsp_q (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire i2cm_pkg::rsp_item_type push_item,
   output logic                        full,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output i2cm_pkg::rsp_item_type      rsp_item
);
   import i2cm_pkg::*;

   rsp_item_type head_ff;
   rsp_item_type tail_ff;
   logic [1:0]   count_ff;
   logic         pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_item  = head_ff;

   // Track occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // Shift up on pop, write new item into the first free slot
   always_ff @(posedge clock) begin
      if (pop && count_ff == 2'd2) begin
         head_ff <= tail_ff;
      end
      if (push) begin
         if ((count_ff - {1'b0, pop}) == 2'd0) begin
            head_ff <= push_item;
         end else begin
            tail_ff <= push_item;
         end
      end
   end

   `I2CM_ASSERT_NEVER(a_count_range, clock, reset, count_ff == 2'd3)
   `I2CM_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)
   `I2CM_ASSERT_NEXT(a_pop_shrinks, clock, reset, pop && !push, count_ff == $past(count_ff) - 2'd1)

endmodule

`default_nettype wire

@@ design/i2c_master_reg16_access.sv @@
// Top level of the pin-level I2C master for 16-bit register accesses.
`default_nettype none

// Takes one item per clock and gives exactly one result item per item: the
// sequencer reads its state and the write buffer, computes the new line levels
// and writes the state back in the cycle the item is accepted, and the result
// goes into a two-entry queue. The request side stalls only when that queue
// holds two results not yet taken. The write buffer is a synchronous memory
// whose read port prefetches the entry of the next data byte, so reads never
// stall the sequencer. There is no clearing pass after reset; a write that
// sends more bytes than were pushed sends stale buffer contents. The divider
// register may be written at any time but is meant to change only while idle.
module i2c_master_reg16_access (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [6:0]  req_dev_addr,
   input  wire logic [15:0] req_reg_addr,
   input  wire logic [4:0]  req_byte_count,
   input  wire logic        req_is_read,
   input  wire logic [7:0]  req_wr_byte,
   input  wire logic        req_sda_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_out,
   output logic             rsp_sda_out,
   output logic [7:0]       rsp_read_byte,
   output logic             rsp_read_valid,
   output logic             rsp_read_last,
   output logic             rsp_done_res,
   output logic             rsp_nack_error,
   output logic             rsp_busy_res
);
   import i2cm_pkg::*;

   req_item_type item;
   rsp_item_type seq_res;
   rsp_item_type q_item;
   logic         q_full;
   logic         item_accept;

   assign req_stall   = q_full;
   assign item_accept = req_valid && !q_full;

   assign item.op         = req_op;
   assign item.dev_addr   = req_dev_addr;
   assign item.reg_addr   = req_reg_addr;
   assign item.byte_count = req_byte_count;
   assign item.is_read    = req_is_read;
   assign item.wr_byte    = req_wr_byte;
   assign item.sda_in     = req_sda_in;

   i2cm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_accept (item_accept),
      .item        (item),
      .res         (seq_res)
   );

   i2cm_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (item_accept),
      .push_item (seq_res),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (q_item)
   );

   assign rsp_scl_out    = q_item.scl_out;
   assign rsp_sda_out    = q_item.sda_out;
   assign rsp_read_byte  = q_item.read_byte;
   assign rsp_read_valid = q_item.read_valid;
   assign rsp_read_last  = q_item.read_last;
   assign rsp_done_res   = q_item.done_res;
   assign rsp_nack_error = q_item.nack_error;
   assign rsp_busy_res   = q_item.busy_res;

endmodule

`default_nettype wire
